### rtl/core/scad_pkg.sv
package scad_pkg;

    // result action codes
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_TERM  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    // default queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // keymap rows, index is the scan code, entries past the key rows are zero
    localparam int MAP_ROWS = 64;
    localparam int MAP_AW   = 6;

    // decoded scan code handed from the front to the back
    typedef struct packed {
        t_action            kind;
        logic [MAP_AW-1:0]  idx;
        logic               shift;
        logic               caps;
        logic [1:0]         term;
    } t_req;

    // one finished result
    typedef struct packed {
        t_action     action;
        logic [6:0]  char_code;
        logic [1:0]  term;
    } t_result;

    localparam logic [6:0] MAP_PLAIN [MAP_ROWS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] MAP_SHIFT [MAP_ROWS] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

### rtl/core/scad_fifo.sv
module scad_fifo
    import scad_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/core/scad_front.sv
module scad_front
    import scad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_scan_code,
    output t_req       o_req
);

    localparam logic [7:0] SC_LSHIFT_DN = 8'h2a;
    localparam logic [7:0] SC_LSHIFT_UP = 8'haa;
    localparam logic [7:0] SC_RSHIFT_DN = 8'h36;
    localparam logic [7:0] SC_RSHIFT_UP = 8'hb6;
    localparam logic [7:0] SC_CTRL_DN   = 8'h1d;
    localparam logic [7:0] SC_CTRL_UP   = 8'h9d;
    localparam logic [7:0] SC_ALT_DN    = 8'h38;
    localparam logic [7:0] SC_ALT_UP    = 8'hb8;
    localparam logic [7:0] SC_CAPS      = 8'h3a;
    localparam logic [7:0] SC_KEY_L     = 8'h26;
    localparam logic [7:0] SC_F1        = 8'h3b;
    localparam logic [7:0] SC_F3        = 8'h3d;
    localparam logic [7:0] SC_REL_MIN   = 8'h80;
    localparam logic [7:0] SC_MAP_END   = 8'h3a;

    logic r_lshift, n_lshift;
    logic r_rshift, n_rshift;
    logic r_ctrl,   n_ctrl;
    logic r_alt,    n_alt;
    logic r_caps,   n_caps;

    // modifier flags as they stand after this code
    always_comb begin
        n_lshift = r_lshift;
        n_rshift = r_rshift;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_caps   = r_caps;
        case (i_scan_code)
            SC_LSHIFT_DN: n_lshift = 1'b1;
            SC_LSHIFT_UP: n_lshift = 1'b0;
            SC_RSHIFT_DN: n_rshift = 1'b1;
            SC_RSHIFT_UP: n_rshift = 1'b0;
            SC_CTRL_DN:   n_ctrl   = 1'b1;
            SC_CTRL_UP:   n_ctrl   = 1'b0;
            SC_ALT_DN:    n_alt    = 1'b1;
            SC_ALT_UP:    n_alt    = 1'b0;
            SC_CAPS:      n_caps   = !r_caps;
            default:      n_caps   = r_caps;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lshift <= 1'b0;
            r_rshift <= 1'b0;
            r_ctrl   <= 1'b0;
            r_alt    <= 1'b0;
            r_caps   <= 1'b0;
        end else if (i_accept) begin
            r_lshift <= n_lshift;
            r_rshift <= n_rshift;
            r_ctrl   <= n_ctrl;
            r_alt    <= n_alt;
            r_caps   <= n_caps;
        end
    end

    // classify: releases, terminal switch, clear screen, keymap lookup
    always_comb begin
        o_req.idx   = i_scan_code[MAP_AW-1:0];
        o_req.shift = n_lshift || n_rshift;
        o_req.caps  = n_caps;
        // F1..F3 map to 0..2 from the low two bits
        o_req.term  = i_scan_code[1:0] + 2'd1;
        if (i_scan_code > SC_REL_MIN) begin
            o_req.kind = ACT_NONE;
        end else if (n_alt && i_scan_code >= SC_F1 && i_scan_code <= SC_F3) begin
            o_req.kind = ACT_TERM;
        end else if (n_ctrl && i_scan_code == SC_KEY_L) begin
            o_req.kind = ACT_CLEAR;
        end else if (i_scan_code < SC_MAP_END) begin
            o_req.kind = ACT_CHAR;
        end else begin
            o_req.kind = ACT_NONE;
        end
    end

endmodule

### rtl/core/scad_back.sv
module scad_back
    import scad_pkg::*;
(
    input  t_req    i_req,
    output t_result o_res
);

    logic [6:0] map_char;
    logic [6:0] case_char;
    logic       is_letter;

    // keymap lookup with caps lock case inversion on letters
    always_comb begin
        map_char  = i_req.shift ? MAP_SHIFT[i_req.idx] : MAP_PLAIN[i_req.idx];
        is_letter = (map_char >= 7'h61 && map_char <= 7'h7a)
                 || (map_char >= 7'h41 && map_char <= 7'h5a);
        case_char = (i_req.caps && is_letter) ? (map_char ^ 7'h20) : map_char;
    end

    // build the result
    always_comb begin
        o_res.action    = ACT_NONE;
        o_res.char_code = '0;
        o_res.term      = '0;
        case (i_req.kind)
            ACT_CHAR: begin
                if (case_char != '0) begin
                    o_res.action    = ACT_CHAR;
                    o_res.char_code = case_char;
                end
            end
            ACT_TERM: begin
                o_res.action = ACT_TERM;
                o_res.term   = i_req.term;
            end
            ACT_CLEAR: begin
                o_res.action = ACT_CLEAR;
            end
            default: begin
                o_res.action = ACT_NONE;
            end
        endcase
    end

endmodule

### rtl/core/scan_code_to_ascii_decoder_top.sv
// Scan code set 1 to ASCII decoder. Push one raw scan code per cycle while
// full is low; every code yields exactly one result, popped in order while
// empty is low: action 1 with an ASCII char_code, action 2 with a
// terminal_index for alt+F1..F3, action 3 for ctrl+L, or action 0 for
// releases, modifiers and unmapped keys. Shift, ctrl, alt and caps lock are
// tracked inside and reset to released/off. Throughput is one code per
// clock while full is low, with the flag update in the front registered
// on each accepted code and the keymap lookup in the back combinational;
// each code is registered into a small request queue and its result into
// a result queue before it reaches the outputs; both depths are parameters.
module scan_code_to_ascii_decoder_top
    import scad_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_scan_code,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_action,
    output logic [6:0] o_char_code,
    output logic [1:0] o_terminal_index
);

    t_req              front_req;
    logic [$bits(t_req)-1:0]    mid_data;
    t_req              back_req;
    t_result           back_res;
    logic [$bits(t_result)-1:0] out_data;
    t_result           out_res;
    logic              accept;
    logic              mid_full;
    logic              mid_empty;
    logic              out_full;
    logic              xfer;

    assign full   = mid_full;
    assign accept = push && !mid_full;
    assign xfer   = !mid_empty && !out_full;

    // front: modifier tracking and classification
    scad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_scan_code (i_scan_code),
        .o_req       (front_req)
    );

    // request queue between front and back
    scad_fifo #(
        .W     ($bits(t_req)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_req),
        .o_full  (mid_full),
        .i_pop   (xfer),
        .o_data  (mid_data),
        .o_empty (mid_empty)
    );

    assign back_req = t_req'(mid_data);

    // back: keymap lookup and result build
    scad_back u_back (
        .i_req (back_req),
        .o_res (back_res)
    );

    // result queue toward the consumer
    scad_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (xfer),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign out_res          = t_result'(out_data);
    assign o_action         = out_res.action;
    assign o_char_code      = out_res.char_code;
    assign o_terminal_index = out_res.term;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import scad_pkg::*;

    // scan codes the decoder reacts to
    localparam bit [7:0] SC_LSHIFT  = 8'h2a;
    localparam bit [7:0] SC_RSHIFT  = 8'h36;
    localparam bit [7:0] SC_CTRL    = 8'h1d;
    localparam bit [7:0] SC_ALT     = 8'h38;
    localparam bit [7:0] SC_CAPS    = 8'h3a;
    localparam bit [7:0] SC_L       = 8'h26;
    localparam bit [7:0] SC_F1      = 8'h3b;
    localparam bit [7:0] SC_F3      = 8'h3d;
    localparam bit [7:0] SC_RELEASE = 8'h80;
    localparam int       KEY_ROWS   = 58;

    localparam int N_RANDOM    = 800;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 300;
    localparam int QUIET_FROM  = 450;
    localparam int QUIET_TO    = 600;
    localparam int TAIL_CYCLES = 4;

    typedef struct {
        t_action   action;
        bit [6:0]  char_code;
        bit [1:0]  term;
    } key_result_t;

    typedef struct {
        bit [7:0]    code;
        bit          typed;
        key_result_t res;
    } key_row_t;

    // unshifted and shifted keymaps, index is the scan code
    bit [6:0] plain_keys [KEY_ROWS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
        7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00, 7'h00, 7'h20
    };

    bit [6:0] shift_keys [KEY_ROWS] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
        7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00, 7'h00, 7'h20
    };

    // directed sequence, expectation typed in where it is obvious
    key_row_t directed_rows [26] = '{
        '{8'h00,      1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h02,      1'b1, '{ACT_CHAR,  7'h31, 2'd0}},
        '{8'h1e,      1'b1, '{ACT_CHAR,  7'h61, 2'd0}},
        '{8'h0e,      1'b1, '{ACT_CHAR,  7'h08, 2'd0}},
        '{SC_CAPS,    1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h1e,      1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_LSHIFT,  1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h1e,      1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h2b,      1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h03,      1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'haa,      1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_CAPS,    1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_RSHIFT,  1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h35,      1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'hb6,      1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_CTRL,    1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_L,       1'b1, '{ACT_CLEAR, 7'h00, 2'd0}},
        '{SC_ALT,     1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_F1,      1'b1, '{ACT_TERM,  7'h00, 2'd0}},
        '{8'h3c,      1'b1, '{ACT_TERM,  7'h00, 2'd1}},
        '{SC_F3,      1'b1, '{ACT_TERM,  7'h00, 2'd2}},
        '{SC_L,       1'b0, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'h9d,      1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'hb8,      1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{SC_RELEASE, 1'b1, '{ACT_NONE,  7'h00, 2'd0}},
        '{8'hff,      1'b1, '{ACT_NONE,  7'h00, 2'd0}}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] i_scan_code = 8'h00;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_action;
    logic [6:0] o_char_code;
    logic [1:0] o_terminal_index;

    // predictor state, follows the modifier flags inside the block
    bit lshift_held = 1'b0;
    bit rshift_held = 1'b0;
    bit ctrl_held   = 1'b0;
    bit alt_held    = 1'b0;
    bit caps_on     = 1'b0;

    key_result_t expected_keys [$];
    int          n_errors   = 0;
    int          n_accepted = 0;

    scan_code_to_ascii_decoder_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_scan_code      (i_scan_code),
        .empty            (empty),
        .pop              (pop),
        .o_action         (o_action),
        .o_char_code      (o_char_code),
        .o_terminal_index (o_terminal_index)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // flag update, then command check, then keymap lookup
    function automatic key_result_t decode_key(input bit [7:0] code);
        key_result_t r;
        bit [6:0]    c;
        r = '{ACT_NONE, 7'h00, 2'd0};
        c = 7'h00;
        if (code == SC_LSHIFT) lshift_held = 1'b1;
        if (code == SC_RSHIFT) rshift_held = 1'b1;
        if (code == SC_CTRL) ctrl_held = 1'b1;
        if (code == SC_ALT) alt_held = 1'b1;
        if (code == SC_CAPS) caps_on = !caps_on;
        if (code == (SC_LSHIFT | SC_RELEASE)) lshift_held = 1'b0;
        if (code == (SC_RSHIFT | SC_RELEASE)) rshift_held = 1'b0;
        if (code == (SC_CTRL | SC_RELEASE)) ctrl_held = 1'b0;
        if (code == (SC_ALT | SC_RELEASE)) alt_held = 1'b0;
        if (code <= SC_RELEASE) begin
            if (alt_held && code >= SC_F1 && code <= SC_F3) begin
                r.action = ACT_TERM;
                r.term   = 2'(code - SC_F1);
            end else if (ctrl_held && code == SC_L) begin
                r.action = ACT_CLEAR;
            end else if (code < KEY_ROWS) begin
                c = (lshift_held || rshift_held) ? shift_keys[code] : plain_keys[code];
                // caps lock flips the case of letters only
                if (caps_on && ((c >= 7'h61 && c <= 7'h7a) || (c >= 7'h41 && c <= 7'h5a)))
                    c = c ^ 7'h20;
                if (c != 7'h00) begin
                    r.action    = ACT_CHAR;
                    r.char_code = c;
                end
            end
        end
        return r;
    endfunction

    // mostly typing with modifiers, the rest any byte at all
    function automatic bit [7:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(0, KEY_ROWS - 1));
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0: return SC_LSHIFT;
                1: return SC_RSHIFT;
                2: return SC_CTRL;
                3: return SC_ALT;
                default: return SC_CAPS;
            endcase
        end
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return SC_LSHIFT | SC_RELEASE;
                1: return SC_RSHIFT | SC_RELEASE;
                2: return SC_CTRL | SC_RELEASE;
                default: return SC_ALT | SC_RELEASE;
            endcase
        end
        if (r < 80) return ($urandom_range(0, 3) == 0) ? SC_L : 8'($urandom_range(SC_F1, SC_F3));
        return 8'($urandom_range(0, 255));
    endfunction

    // random idling, switched off for one stretch of the run
    function automatic bit take_break();
        if (n_accepted >= QUIET_FROM && n_accepted < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < 8;
    endfunction

    // offer one request and record its expected result once accepted
    task automatic send_code(input bit [7:0] code, input bit typed, input key_result_t typed_res);
        key_result_t r;
        if (take_break()) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_scan_code <= code;
        do @(posedge i_clk); while (full);
        r = decode_key(code);
        if (typed) r = typed_res;
        expected_keys.push_back(r);
        n_accepted++;
    endtask

    // receiver side: check each popped result, then decide on the next pop
    initial begin
        key_result_t exp_res;
        int          hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_keys.size() == 0) begin
                    $error("result popped with none expected: action %0d", o_action);
                    n_errors++;
                end else begin
                    exp_res = expected_keys.pop_front();
                    if (o_action !== exp_res.action) begin
                        $error("action: expected %0d, got %0d", exp_res.action, o_action);
                        n_errors++;
                    end
                    if (o_char_code !== exp_res.char_code) begin
                        $error("char_code: expected %h, got %h",
                               exp_res.char_code, o_char_code);
                        n_errors++;
                    end
                    if (o_terminal_index !== exp_res.term) begin
                        $error("terminal_index: expected %0d, got %0d",
                               exp_res.term, o_terminal_index);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block backs up and raises full
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !take_break();
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) stall = 0;
            else stall++;
            if (stall >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // reset, directed sequence, random typing, then drain
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[k])
            send_code(directed_rows[k].code, directed_rows[k].typed, directed_rows[k].res);
        for (int k = 0; k < N_RANDOM; k++)
            send_code(pick_code(), 1'b0, '{ACT_NONE, 7'h00, 2'd0});
        push <= 1'b0;
        while (expected_keys.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/core/scad_pkg.sv
rtl/core/scad_fifo.sv
rtl/core/scad_front.sv
rtl/core/scad_back.sv
rtl/core/scan_code_to_ascii_decoder_top.sv
tb/testbench.sv
